// ----- rtl/low_rank_adapter_forward_merge_assert.svh -----
// Assertion macros for the low-rank adapter block.
`ifndef LOW_RANK_ADAPTER_FORWARD_MERGE_ASSERT_SVH
`define LOW_RANK_ADAPTER_FORWARD_MERGE_ASSERT_SVH
`ifndef SYNTHESIS
`define LRAFM_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("lrafm assertion failed");
`define LRAFM_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("lrafm assertion failed");
`else
`define LRAFM_ASSERT_IMPLY(lbl, clk, rst_n, a, b)
`define LRAFM_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

// ----- rtl/lrafm_pkg.sv -----
// Shared types, codes and arithmetic helpers of the low-rank adapter block.
`default_nettype none
package lrafm_pkg;

	typedef enum logic [1:0] {
		KIND_LOAD_A = 2'd0,
		KIND_LOAD_B = 2'd1,
		KIND_VECTOR = 2'd2,
		KIND_WEIGHT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_ACC_HIDDEN = 2'd0,
		OP_OUT_DOT    = 2'd1,
		OP_MERGE_DOT  = 2'd2
	} op_t;

	localparam logic [1:0] CFG_RANK   = 2'd0;
	localparam logic [1:0] CFG_INPUTS = 2'd1;
	localparam logic [1:0] CFG_OUTPUTS = 2'd2;
	localparam logic [1:0] CFG_SCALE  = 2'd3;

	localparam logic RESULT_FORWARD = 1'b0;
	localparam logic RESULT_MERGED  = 1'b1;

	typedef struct packed {
		logic              step;
		op_t               op;
		logic              first;
		logic              last;
		logic              clear;
		logic              load_a;
		logic              load_b;
		logic signed [31:0] value;
		logic [13:0]       position;
		logic              result_last;
	} dp_cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic out_valid;
	} dp_status_t;

	function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
		logic signed [31:0] r;
		if (v > 49'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -49'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/lrafm_in_if.sv -----
// Input channel: element kind and value with valid/ready.
`default_nettype none
interface lrafm_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic signed [31:0] value;
	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface
`default_nettype wire

// ----- rtl/lrafm_out_if.sv -----
// Result channel: value, kind, position and last flag with valid/ready.
`default_nettype none
interface lrafm_out_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] result_value;
	logic              result_kind;
	logic [13:0]       position;
	logic              last;
	modport source (output valid, output result_value, output result_kind,
		output position, output last, input ready);
	modport sink (input valid, input result_value, input result_kind,
		input position, input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/lrafm_ctrl.sv -----
// Controller: position counters, weight index recovery and rank-step sequencing.
`default_nettype none
module lrafm_ctrl #(
	parameter int MAX_RANK = 16,
	parameter int MAX_INPUTS = 256,
	parameter int MAX_OUTPUTS = 64,
	localparam int RKN = $clog2(MAX_RANK + 1),
	localparam int NIW = $clog2(MAX_INPUTS + 1),
	localparam int NOW = $clog2(MAX_OUTPUTS + 1),
	localparam int RKW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1,
	localparam int AAW = (MAX_RANK * MAX_INPUTS > 1) ? $clog2(MAX_RANK * MAX_INPUTS) : 1,
	localparam int BAW = (MAX_OUTPUTS * MAX_RANK > 1) ? $clog2(MAX_OUTPUTS * MAX_RANK) : 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [RKN-1:0]     rk,
	input  wire logic [NIW-1:0]     ni,
	input  wire logic [NOW-1:0]     no,
	input  wire logic               cfg_we,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         in_kind,
	input  wire logic signed [31:0] in_value,
	input  lrafm_pkg::dp_status_t   status,
	output lrafm_pkg::dp_cmd_t      cmd,
	output logic [AAW-1:0]          a_addr,
	output logic [BAW-1:0]          b_addr,
	output logic [RKW-1:0]          h_idx
);
	localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int OW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
	localparam int WPW = (MAX_OUTPUTS * MAX_INPUTS > 1) ?
		$clog2(MAX_OUTPUTS * MAX_INPUTS) : 1;
	localparam int CW = WPW + NIW + 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DIV   = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_ISSUE = 4'b1000
	} state_t;

	state_t             state_q;
	lrafm_pkg::op_t     mode_q;
	logic [RKW-1:0]     r_q;
	logic [OW-1:0]      o_q;
	logic [IW-1:0]      vi_q;
	logic               elem_last_q;
	logic               clear_q;
	logic signed [31:0] x_q;
	logic [AAW-1:0]     dpos_q;
	logic [BAW-1:0]     upos_q;
	logic [IW-1:0]      vpos_q;
	logic [WPW-1:0]     wpos_q;
	logic [WPW-1:0]     cur_q;
	logic               wlast_q;
	logic [WPW-1:0]     rem_q;
	logic [OW-1:0]      wo_q;
	logic [IW-1:0]      wi_q;
	logic               dirty_q;

	logic [AAW:0]   na;
	logic [BAW:0]   nb;
	logic [WPW:0]   nw;
	logic [AAW-1:0] ld_a;
	logic [BAW-1:0] ld_b;
	logic [IW-1:0]  vstart;
	logic [WPW-1:0] wstart;
	logic           accept;
	logic           rank_end;
	logic [IW-1:0]  col;
	logic [OW-1:0]  row;

	assign na = (AAW + 1)'(rk) * (AAW + 1)'(ni);
	assign nb = (BAW + 1)'(no) * (BAW + 1)'(rk);
	assign nw = (WPW + 1)'(no) * (WPW + 1)'(ni);

	assign ld_a = ((AAW + 1)'(dpos_q) >= na) ? '0 : dpos_q;
	assign ld_b = ((BAW + 1)'(upos_q) >= nb) ? '0 : upos_q;
	assign vstart = (NIW'(vpos_q) >= ni) ? '0 : vpos_q;
	assign wstart = ((WPW + 1)'(wpos_q) >= nw) ? '0 : wpos_q;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign rank_end = (RKN'(r_q) + RKN'(1)) == rk;

	assign col = (mode_q == lrafm_pkg::OP_MERGE_DOT) ? wi_q : vi_q;
	assign row = (mode_q == lrafm_pkg::OP_MERGE_DOT) ? wo_q : o_q;
	assign h_idx = r_q;

	always_comb begin
		cmd = '0;
		cmd.op = mode_q;
		cmd.value = x_q;
		cmd.first = (r_q == '0);
		cmd.last = rank_end;
		cmd.clear = clear_q;
		a_addr = AAW'((AAW + 1)'(r_q) * (AAW + 1)'(ni) + (AAW + 1)'(col));
		b_addr = BAW'((BAW + 1)'(row) * (BAW + 1)'(rk) + (BAW + 1)'(r_q));
		if (mode_q == lrafm_pkg::OP_MERGE_DOT) begin
			cmd.position = 14'(cur_q);
			cmd.result_last = wlast_q;
		end else begin
			cmd.position = 14'(o_q);
			cmd.result_last = (NOW'(o_q) + NOW'(1)) == no;
		end
		if (state_q == ST_ISSUE) begin
			cmd.step = 1'b1;
		end
		if (state_q == ST_IDLE) begin
			cmd.value = in_value;
			cmd.load_a = accept && (in_kind == lrafm_pkg::KIND_LOAD_A);
			cmd.load_b = accept && (in_kind == lrafm_pkg::KIND_LOAD_B);
			a_addr = ld_a;
			b_addr = ld_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= lrafm_pkg::OP_ACC_HIDDEN;
			r_q <= '0;
			o_q <= '0;
			vi_q <= '0;
			elem_last_q <= 1'b0;
			clear_q <= 1'b0;
			x_q <= '0;
			dpos_q <= '0;
			upos_q <= '0;
			vpos_q <= '0;
			wpos_q <= '0;
			cur_q <= '0;
			wlast_q <= 1'b0;
			rem_q <= '0;
			wo_q <= '0;
			wi_q <= '0;
			dirty_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				dirty_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						x_q <= in_value;
						unique case (lrafm_pkg::kind_t'(in_kind))
							lrafm_pkg::KIND_LOAD_A: begin
								dpos_q <= ((AAW + 1)'(ld_a) + (AAW + 1)'(1) >= na) ?
									'0 : ld_a + AAW'(1);
							end
							lrafm_pkg::KIND_LOAD_B: begin
								upos_q <= ((BAW + 1)'(ld_b) + (BAW + 1)'(1) >= nb) ?
									'0 : ld_b + BAW'(1);
							end
							lrafm_pkg::KIND_VECTOR: begin
								mode_q <= lrafm_pkg::OP_ACC_HIDDEN;
								vi_q <= vstart;
								clear_q <= (vstart == '0);
								elem_last_q <= (NIW'(vstart) + NIW'(1)) >= ni;
								vpos_q <= ((NIW'(vstart) + NIW'(1)) >= ni) ?
									'0 : vstart + IW'(1);
								state_q <= ST_WAIT;
							end
							lrafm_pkg::KIND_WEIGHT: begin
								mode_q <= lrafm_pkg::OP_MERGE_DOT;
								cur_q <= wstart;
								wlast_q <= ((WPW + 1)'(wstart) + (WPW + 1)'(1)) >= nw;
								if ((WPW + 1)'(wpos_q) >= nw) begin
									wo_q <= '0;
									wi_q <= '0;
									dirty_q <= 1'b0;
									state_q <= ST_WAIT;
								end else if (dirty_q || cfg_we) begin
									rem_q <= wpos_q;
									wo_q <= '0;
									state_q <= ST_DIV;
								end else begin
									state_q <= ST_WAIT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_DIV: begin
					// Recover row and column of the weight position by repeated
					// subtraction of the row length.
					if (CW'(rem_q) >= CW'(ni)) begin
						rem_q <= rem_q - WPW'(ni);
						wo_q <= wo_q + OW'(1);
					end else begin
						wi_q <= IW'(rem_q);
						dirty_q <= 1'b0;
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (!status.pipe_busy && ((mode_q == lrafm_pkg::OP_ACC_HIDDEN) ||
						!status.out_valid)) begin
						r_q <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					r_q <= r_q + RKW'(1);
					if (rank_end) begin
						r_q <= '0;
						unique case (mode_q)
							lrafm_pkg::OP_ACC_HIDDEN: begin
								if (elem_last_q) begin
									mode_q <= lrafm_pkg::OP_OUT_DOT;
									o_q <= '0;
									state_q <= ST_WAIT;
								end else begin
									state_q <= ST_IDLE;
								end
							end
							lrafm_pkg::OP_OUT_DOT: begin
								if ((NOW'(o_q) + NOW'(1)) == no) begin
									state_q <= ST_IDLE;
								end else begin
									o_q <= o_q + OW'(1);
									state_q <= ST_WAIT;
								end
							end
							lrafm_pkg::OP_MERGE_DOT: begin
								state_q <= ST_IDLE;
								if (wlast_q) begin
									wpos_q <= '0;
									wo_q <= '0;
									wi_q <= '0;
								end else begin
									wpos_q <= cur_q + WPW'(1);
									if ((NIW'(wi_q) + NIW'(1)) >= ni) begin
										wi_q <= '0;
										wo_q <= wo_q + OW'(1);
									end else begin
										wi_q <= wi_q + IW'(1);
									end
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/lrafm_dp.sv -----
// Datapath: weight memories, hidden sums, multiply-accumulate pipe and result register.
`default_nettype none
module lrafm_dp #(
	parameter int MAX_RANK = 16,
	parameter int MAX_INPUTS = 256,
	parameter int MAX_OUTPUTS = 64,
	localparam int RKW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1,
	localparam int AAW = (MAX_RANK * MAX_INPUTS > 1) ? $clog2(MAX_RANK * MAX_INPUTS) : 1,
	localparam int BAW = (MAX_OUTPUTS * MAX_RANK > 1) ? $clog2(MAX_OUTPUTS * MAX_RANK) : 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  lrafm_pkg::dp_cmd_t      cmd,
	input  wire logic [AAW-1:0]     a_addr,
	input  wire logic [BAW-1:0]     b_addr,
	input  wire logic [RKW-1:0]     h_idx,
	input  wire logic [15:0]        scale,
	output lrafm_pkg::dp_status_t   status,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output logic signed [31:0]      out_value,
	output logic                    out_kind,
	output logic [13:0]             out_position,
	output logic                    out_last
);
	localparam int A_DEPTH = MAX_RANK * MAX_INPUTS;
	localparam int B_DEPTH = MAX_OUTPUTS * MAX_RANK;

	logic signed [31:0] mem_a [A_DEPTH];
	logic signed [31:0] mem_b [B_DEPTH];
	logic signed [31:0] mem_h [MAX_RANK];

	logic               v_s1, v_s2, fin_s3, fin_s4, out_valid_q;
	lrafm_pkg::op_t     op_s1, op_s2, op_s3, op_s4;
	logic               first_s1, first_s2, last_s1, last_s2, clear_s1;
	logic [RKW-1:0]     r_s1, r_s2;
	logic signed [31:0] val_s1, val_s2, val_s3, val_s4;
	logic [13:0]        pos_s1, pos_s2, pos_s3, pos_s4;
	logic               rl_s1, rl_s2, rl_s3, rl_s4;
	logic signed [31:0] a_rd_s1, b_rd_s1, h_rd_s1;
	logic signed [47:0] prod_s2;
	logic signed [31:0] hold_s2;
	logic signed [31:0] acc_q;
	logic signed [40:0] scl_s4;

	logic signed [31:0] opx, opy;
	logic signed [63:0] prod;
	logic signed [48:0] acc_sum, h_sum;
	logic signed [48:0] scl_full;
	logic signed [31:0] scaled;
	logic signed [31:0] merged;

	always_ff @(posedge clk) begin
		if (cmd.load_a) begin
			mem_a[a_addr] <= cmd.value;
		end
		a_rd_s1 <= mem_a[a_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_b) begin
			mem_b[b_addr] <= cmd.value;
		end
		b_rd_s1 <= mem_b[b_addr];
	end

	always_ff @(posedge clk) begin
		if (v_s2 && (op_s2 == lrafm_pkg::OP_ACC_HIDDEN)) begin
			mem_h[r_s2] <= lrafm_pkg::sat32(h_sum);
		end
		h_rd_s1 <= mem_h[h_idx];
	end

	always_comb begin
		unique case (op_s1)
			lrafm_pkg::OP_ACC_HIDDEN: begin
				opx = a_rd_s1;
				opy = val_s1;
			end
			lrafm_pkg::OP_OUT_DOT: begin
				opx = h_rd_s1;
				opy = b_rd_s1;
			end
			default: begin
				opx = b_rd_s1;
				opy = a_rd_s1;
			end
		endcase
	end

	// Arithmetic right shift of the product drops the low bits toward minus infinity.
	assign prod = opx * opy;
	assign h_sum = 49'(prod_s2) + 49'(hold_s2);
	assign acc_sum = 49'(prod_s2) + (first_s2 ? 49'sd0 : 49'(acc_q));
	assign scl_full = 49'(acc_q) * $signed({33'd0, scale});
	assign scaled = lrafm_pkg::sat32(49'(scl_s4));
	assign merged = lrafm_pkg::sat32(49'(val_s4) + 49'(scaled));

	always_ff @(posedge clk) begin
		val_s1 <= cmd.value;
		op_s1 <= cmd.op;
		first_s1 <= cmd.first;
		last_s1 <= cmd.last;
		clear_s1 <= cmd.clear;
		r_s1 <= h_idx;
		pos_s1 <= cmd.position;
		rl_s1 <= cmd.result_last;
		prod_s2 <= prod[63:16];
		hold_s2 <= clear_s1 ? 32'sd0 : h_rd_s1;
		val_s2 <= val_s1;
		op_s2 <= op_s1;
		first_s2 <= first_s1;
		last_s2 <= last_s1;
		r_s2 <= r_s1;
		pos_s2 <= pos_s1;
		rl_s2 <= rl_s1;
		if (v_s2 && (op_s2 != lrafm_pkg::OP_ACC_HIDDEN)) begin
			acc_q <= lrafm_pkg::sat32(acc_sum);
		end
		val_s3 <= val_s2;
		op_s3 <= op_s2;
		pos_s3 <= pos_s2;
		rl_s3 <= rl_s2;
		scl_s4 <= scl_full[48:8];
		val_s4 <= val_s3;
		op_s4 <= op_s3;
		pos_s4 <= pos_s3;
		rl_s4 <= rl_s3;
		if (fin_s4) begin
			out_value <= (op_s4 == lrafm_pkg::OP_MERGE_DOT) ? merged : scaled;
			out_kind <= (op_s4 == lrafm_pkg::OP_MERGE_DOT) ?
				lrafm_pkg::RESULT_MERGED : lrafm_pkg::RESULT_FORWARD;
			out_position <= pos_s4;
			out_last <= rl_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			fin_s3 <= 1'b0;
			fin_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.step;
			v_s2 <= v_s1;
			fin_s3 <= v_s2 && last_s2 && (op_s2 != lrafm_pkg::OP_ACC_HIDDEN);
			fin_s4 <= fin_s3;
			if (fin_s4) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status.pipe_busy = v_s1 || v_s2 || fin_s3 || fin_s4;
	assign status.out_valid = out_valid_q;
endmodule
`default_nettype wire

// ----- rtl/low_rank_adapter_forward_merge.sv -----
// Top level of the low-rank adapter: configuration registers, controller and datapath.
//
// Channel  Direction  Transaction
// in_ch    sink       one element: kind (load A, load B, vector, base weight) and value
// out_ch   source     one result: value, kind, position, last flag
// cfg      write      register index and data, taken on cfg_we
//
// A vector element or base weight issues rank_in_use steps on the shared
// multiply-accumulate pipe once the pipe has drained; each forward output
// issues rank_in_use further steps. After a configuration write the first
// base weight also recovers its row by repeated subtraction.
// Reset clears all control state; the weight memories hold nothing until written.
// A stalled result stays in the output register while loads keep being accepted.
`default_nettype none
`include "low_rank_adapter_forward_merge_assert.svh"
module low_rank_adapter_forward_merge #(
	parameter int MAX_RANK = 16,
	parameter int MAX_INPUTS = 256,
	parameter int MAX_OUTPUTS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	lrafm_in_if.sink         in_ch,
	lrafm_out_if.source      out_ch,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	localparam int RKN = $clog2(MAX_RANK + 1);
	localparam int NIW = $clog2(MAX_INPUTS + 1);
	localparam int NOW = $clog2(MAX_OUTPUTS + 1);
	localparam int RKW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
	localparam int AAW = (MAX_RANK * MAX_INPUTS > 1) ? $clog2(MAX_RANK * MAX_INPUTS) : 1;
	localparam int BAW = (MAX_OUTPUTS * MAX_RANK > 1) ? $clog2(MAX_OUTPUTS * MAX_RANK) : 1;

	// Raw register values as written by the host.
	logic [4:0]  rank_q;
	logic [8:0]  inputs_q;
	logic [6:0]  outputs_q;
	logic [15:0] scale_q;

	// Clamped working sizes.
	logic [RKN-1:0] rk;
	logic [NIW-1:0] ni;
	logic [NOW-1:0] no;

	lrafm_pkg::dp_cmd_t    cmd;
	lrafm_pkg::dp_status_t status;
	logic [AAW-1:0]        a_addr;
	logic [BAW-1:0]        b_addr;
	logic [RKW-1:0]        h_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= 5'd1;
			inputs_q <= 9'd256;
			outputs_q <= 7'd64;
			scale_q <= 16'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lrafm_pkg::CFG_RANK:    rank_q <= cfg_data[4:0];
				lrafm_pkg::CFG_INPUTS:  inputs_q <= cfg_data[8:0];
				lrafm_pkg::CFG_OUTPUTS: outputs_q <= cfg_data[6:0];
				default:                scale_q <= cfg_data;
			endcase
		end
	end

	// Sizes of zero are treated as one, and sizes beyond the storage are cut to it.
	assign rk = (rank_q == '0) ? RKN'(1) :
		(int'(rank_q) > MAX_RANK) ? RKN'(MAX_RANK) : RKN'(rank_q);
	assign ni = (inputs_q == '0) ? NIW'(1) :
		(int'(inputs_q) > MAX_INPUTS) ? NIW'(MAX_INPUTS) : NIW'(inputs_q);
	assign no = (outputs_q == '0) ? NOW'(1) :
		(int'(outputs_q) > MAX_OUTPUTS) ? NOW'(MAX_OUTPUTS) : NOW'(outputs_q);

	lrafm_ctrl #(
		.MAX_RANK(MAX_RANK),
		.MAX_INPUTS(MAX_INPUTS),
		.MAX_OUTPUTS(MAX_OUTPUTS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.rk(rk),
		.ni(ni),
		.no(no),
		.cfg_we(cfg_we),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.in_kind(in_ch.kind),
		.in_value(in_ch.value),
		.status(status),
		.cmd(cmd),
		.a_addr(a_addr),
		.b_addr(b_addr),
		.h_idx(h_idx)
	);

	lrafm_dp #(
		.MAX_RANK(MAX_RANK),
		.MAX_INPUTS(MAX_INPUTS),
		.MAX_OUTPUTS(MAX_OUTPUTS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.a_addr(a_addr),
		.b_addr(b_addr),
		.h_idx(h_idx),
		.scale(scale_q),
		.status(status),
		.out_ready(out_ch.ready),
		.out_valid(out_ch.valid),
		.out_value(out_ch.result_value),
		.out_kind(out_ch.result_kind),
		.out_position(out_ch.position),
		.out_last(out_ch.last)
	);

	// A group of rank steps only starts on a drained pipe.
	`LRAFM_ASSERT_IMPLY(a_group_start_drained, clk, arst_n, cmd.step && cmd.first, !status.pipe_busy)
	// Steps that produce a result never run while an earlier result is still waiting.
	`LRAFM_ASSERT_IMPLY(a_dot_out_free, clk, arst_n, cmd.step && (cmd.op != lrafm_pkg::OP_ACC_HIDDEN), !status.out_valid)
	// A weight load never coincides with a rank step.
	`LRAFM_ASSERT_IMPLY(a_load_not_step, clk, arst_n, cmd.load_a || cmd.load_b, !cmd.step)
	// The last step of a result group, issued on a busy pipe with no result waiting, leaves the pipe busy behind it.
	`LRAFM_ASSERT_NEXT(a_fin_to_out, clk, arst_n, status.pipe_busy && !status.out_valid && cmd.step && cmd.last && (cmd.op != lrafm_pkg::OP_ACC_HIDDEN), status.pipe_busy)
endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the low-rank adapter: forward passes, weight merges and loads.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import lrafm_pkg::*;

	// One expected or observed result transaction.
	typedef struct packed {
		logic signed [31:0] result_value;
		logic               result_kind;
		logic [13:0]        position;
		logic               last;
	} adapter_result_t;

	// Mirrors the adapter state and holds the results that are still owed.
	class adapter_scoreboard;
		logic signed [31:0] down_w[4096];
		logic signed [31:0] up_w[1024];
		logic signed [31:0] hidden[16];
		int unsigned        a_pos, b_pos, v_pos, w_pos;
		logic [4:0]         rank_reg;
		logic [8:0]         inputs_reg;
		logic [6:0]         outputs_reg;
		logic [15:0]        scale_reg;
		adapter_result_t    owed[$];
		int                 errors;

		function new();
			foreach (hidden[r]) hidden[r] = '0;
			a_pos = 0;
			b_pos = 0;
			v_pos = 0;
			w_pos = 0;
			rank_reg = 5'd1;
			inputs_reg = 9'd256;
			outputs_reg = 7'd64;
			scale_reg = 16'd256;
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] data);
			case (idx)
				CFG_RANK: rank_reg = data[4:0];
				CFG_INPUTS: inputs_reg = data[8:0];
				CFG_OUTPUTS: outputs_reg = data[6:0];
				default: scale_reg = data;
			endcase
		endfunction

		function int unsigned rank();
			return (rank_reg < 1) ? 1 : (rank_reg > 16) ? 16 : rank_reg;
		endfunction
		function int unsigned n_in();
			return (inputs_reg < 1) ? 1 : (inputs_reg > 256) ? 256 : inputs_reg;
		endfunction
		function int unsigned n_out();
			return (outputs_reg < 1) ? 1 : (outputs_reg > 64) ? 64 : outputs_reg;
		endfunction

		function longint sat(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		// Q16.16 product, low bits dropped (floor).
		function longint qmul(longint a, longint b);
			return (a * b) >>> 16;
		endfunction

		function longint scaled(longint s);
			return sat((s * longint'(scale_reg)) >>> 8);
		endfunction

		function void owe(longint v, logic k, int unsigned pos, logic lst);
			adapter_result_t e;
			e.result_value = v[31:0];
			e.result_kind = k;
			e.position = pos[13:0];
			e.last = lst;
			owed.push_back(e);
		endfunction

		function void note_input(kind_t k, logic signed [31:0] v);
			int unsigned rk, ni, no, n, o, i;
			longint s;
			rk = rank();
			ni = n_in();
			no = n_out();
			case (k)
				KIND_LOAD_A: begin
					n = rk * ni;
					if (a_pos >= n) a_pos = 0;
					down_w[a_pos] = v;
					a_pos = (a_pos + 1 >= n) ? 0 : a_pos + 1;
				end
				KIND_LOAD_B: begin
					n = no * rk;
					if (b_pos >= n) b_pos = 0;
					up_w[b_pos] = v;
					b_pos = (b_pos + 1 >= n) ? 0 : b_pos + 1;
				end
				KIND_VECTOR: begin
					if (v_pos >= ni) v_pos = 0;
					if (v_pos == 0) foreach (hidden[r]) hidden[r] = '0;
					i = v_pos;
					for (int r = 0; r < rk; r++)
						hidden[r] = sat(longint'(hidden[r]) + qmul(down_w[r * ni + i], v));
					if (i + 1 < ni) begin
						v_pos = i + 1;
					end else begin
						v_pos = 0;
						for (o = 0; o < no; o++) begin
							s = 0;
							for (int r = 0; r < rk; r++)
								s = sat(s + qmul(hidden[r], up_w[o * rk + r]));
							owe(scaled(s), RESULT_FORWARD, o, o + 1 == no);
						end
					end
				end
				default: begin
					n = no * ni;
					if (w_pos >= n) w_pos = 0;
					o = w_pos / ni;
					i = w_pos % ni;
					s = 0;
					for (int r = 0; r < rk; r++)
						s = sat(s + qmul(up_w[o * rk + r], down_w[r * ni + i]));
					owe(sat(longint'(v) + scaled(s)), RESULT_MERGED, w_pos, w_pos + 1 == n);
					w_pos = (w_pos + 1 >= n) ? 0 : w_pos + 1;
				end
			endcase
		endfunction

		function void check_result(adapter_result_t got);
			adapter_result_t e;
			if (owed.size() == 0) begin
				$error("unexpected result transaction, value %0d", got.result_value);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (got.result_value !== e.result_value) begin
				$error("result_value expected %0d actual %0d", e.result_value, got.result_value);
				errors++;
			end
			if (got.result_kind !== e.result_kind) begin
				$error("result_kind expected %0d actual %0d", e.result_kind, got.result_kind);
				errors++;
			end
			if (got.position !== e.position) begin
				$error("position expected %0d actual %0d", e.position, got.position);
				errors++;
			end
			if (got.last !== e.last) begin
				$error("last expected %0d actual %0d", e.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	lrafm_in_if in_ch();
	lrafm_out_if out_ch();

	low_rank_adapter_forward_merge dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	adapter_scoreboard sb = new();

	// While calm is set neither side idles; hold_cycles makes the receiver
	// refuse results for a long stretch so the block backs up into its input.
	bit calm = 0;
	int hold_cycles = 0;

	always #5 clk = ~clk;

	// Receiver: random stalls, plus the long hold-off when requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ch.ready <= 1'b0;
				hold_cycles--;
			end else begin
				out_ch.ready <= calm || ($urandom_range(99) >= 7);
			end
		end
	end

	// Results are taken from the values present just before the clock edge.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result({out_ch.result_value, out_ch.result_kind, out_ch.position,
				out_ch.last});
	end

	// Offer one transaction; valid stays high until the block takes it, and the
	// predictor sees the item at the edge where it is accepted.
	task automatic send(kind_t k, logic [31:0] v);
		while (!calm && $urandom_range(99) < 7) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= k;
		in_ch.value <= v;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_input(k, v);
	endtask

	// Mostly values within a few units so the sums stay meaningful,
	// and a quarter of the time the whole 32-bit range.
	function automatic logic [31:0] pick_value();
		if ($urandom_range(3) == 0) return $urandom;
		return $urandom_range(32'h0004_0000) - 32'h0002_0000;
	endfunction

	// Registers are only written once the block has drained; a load or a
	// non-final vector element may still be in the pipe, so allow slack.
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic configure(logic [15:0] rk, logic [15:0] ni, logic [15:0] no,
		logic [15:0] scl);
		logic [15:0] vals[4];
		vals = '{rk, ni, no, scl};
		settle();
		for (int idx = 0; idx < 4; idx++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[1:0];
			cfg_data <= vals[idx];
			@(posedge clk);
			sb.write_reg(idx[1:0], vals[idx]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Fill both matrices completely; wrap makes any n consecutive loads cover them.
	task automatic load_all();
		int unsigned na, nb;
		na = sb.rank() * sb.n_in();
		nb = sb.n_out() * sb.rank();
		for (int j = 0; j < na; j++) send(KIND_LOAD_A, pick_value());
		for (int j = 0; j < nb; j++) send(KIND_LOAD_B, pick_value());
	endtask

	// Random mix: mostly vector elements and base weights, some reloads.
	task automatic random_items(int count);
		int unsigned sel;
		for (int j = 0; j < count; j++) begin
			sel = $urandom_range(99);
			if (sel < 45) send(KIND_VECTOR, pick_value());
			else if (sel < 85) send(KIND_WEIGHT, pick_value());
			else if (sel < 93) send(KIND_LOAD_A, pick_value());
			else send(KIND_LOAD_B, pick_value());
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_RANK;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_LOAD_A;
		in_ch.value = '0;
		out_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a small adapter with extreme elements, so hidden sums,
		// outputs and merged weights all saturate in both directions.
		configure(2, 3, 2, 256);
		send(KIND_LOAD_A, 32'h7fff_ffff);
		send(KIND_LOAD_A, 32'h8000_0000);
		send(KIND_LOAD_A, 32'h0001_0000);
		send(KIND_LOAD_A, 32'h7fff_ffff);
		send(KIND_LOAD_A, 32'h7fff_ffff);
		send(KIND_LOAD_A, 32'hffff_ffff);
		send(KIND_LOAD_B, 32'h7fff_ffff);
		send(KIND_LOAD_B, 32'h8000_0000);
		send(KIND_LOAD_B, 32'h0000_0001);
		send(KIND_LOAD_B, 32'h0002_0000);
		send(KIND_VECTOR, 32'h7fff_ffff);
		send(KIND_VECTOR, 32'h8000_0000);
		send(KIND_VECTOR, 32'h0000_ffff);
		send(KIND_WEIGHT, 32'h7fff_ffff);
		send(KIND_WEIGHT, 32'h8000_0000);
		send(KIND_WEIGHT, 32'h0000_0000);
		send(KIND_WEIGHT, 32'hffff_ffff);
		send(KIND_WEIGHT, 32'h7fff_0000);
		send(KIND_WEIGHT, 32'h8000_ffff);
		// A partial vector pass, then a register change that leaves its
		// position beyond the new input width so the pass restarts.
		send(KIND_VECTOR, 32'h0001_0000);
		send(KIND_VECTOR, 32'h0002_0000);

		// Registers of zero clamp up to one; scale of zero kills the delta.
		configure(0, 0, 0, 0);
		load_all();
		random_items(15);

		// Full rank, maximum scale, no idling on either side.
		calm = 1;
		configure(16, 4, 3, 16'hffff);
		load_all();
		random_items(30);
		calm = 0;

		// Out-of-range rank and output width clamp to their maxima.
		configure(31, 5, 127, 1);
		load_all();
		random_items(12);

		// The largest adapter: one complete forward pass and a few random items.
		configure(16, 256, 64, 384);
		load_all();
		for (int j = 0; j < 256; j++) send(KIND_VECTOR, pick_value());
		random_items(6);

		// Input width above the maximum clamps to it.
		configure(1, 16'h01ff, 2, 512);
		load_all();
		random_items(8);

		// Main random phase, with one long receiver hold-off while the
		// sender keeps offering vector elements and weights.
		configure(4, 3, 5, 128);
		load_all();
		random_items(20);
		hold_cycles = 400;
		random_items(180);

		settle();
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("tb_top NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

// ----- low_rank_adapter_forward_merge.f -----
+incdir+rtl
rtl/lrafm_pkg.sv
rtl/lrafm_in_if.sv
rtl/lrafm_out_if.sv
rtl/lrafm_ctrl.sv
rtl/lrafm_dp.sv
rtl/low_rank_adapter_forward_merge.sv
verif/tb_top.sv
